// File: design/rri_pkg.sv
`default_nettype none

package rri_pkg;

    localparam int COORD_W = 20;
    localparam int NUM_W   = 43;
    localparam int MAG_W   = 42;
    localparam int QUO_W   = 33;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [3*COORD_W-1:0]      vec_packed_t;
    typedef logic [47:0]               len_t;
    typedef logic [2:0]                reason_t;
    typedef logic [2:0]                cfg_index_t;

    localparam reason_t REASON_HIT       = 3'd0;
    localparam reason_t REASON_PARALLEL  = 3'd1;
    localparam reason_t REASON_OUTSIDE_U = 3'd2;
    localparam reason_t REASON_OUTSIDE_V = 3'd3;
    localparam reason_t REASON_BEHIND    = 3'd4;

    localparam cfg_index_t CFG_CORNER = 3'd0;
    localparam cfg_index_t CFG_LEG_U  = 3'd1;
    localparam cfg_index_t CFG_LEG_V  = 3'd2;
    localparam cfg_index_t CFG_NORMAL = 3'd3;
    localparam cfg_index_t CFG_LEN_U  = 3'd4;
    localparam cfg_index_t CFG_LEN_V  = 3'd5;

    typedef struct packed {
        coord_t ox;
        coord_t oy;
        coord_t oz;
        coord_t dx;
        coord_t dy;
        coord_t dz;
    } ray_t;

    typedef struct packed {
        ray_t ray;
        logic parallel;
        logic neg;
        logic den_neg;
    } ray_info_t;

    typedef struct packed {
        logic               is_hit;
        reason_t            miss_reason;
        logic               recorded;
        logic               entering;
        logic signed [31:0] distance;
        coord_t             point_x;
        coord_t             point_y;
        coord_t             point_z;
    } result_t;

    function automatic coord_t comp(input vec_packed_t p, input int unsigned idx);
        return coord_t'(p[idx*COORD_W +: COORD_W]);
    endfunction

endpackage

`default_nettype wire

// File: design/ray_rectangle_intersect_unit.sv
// throughput: one item per cycle; a 33-stage restoring divider carries t
// the whole pipeline holds while a result waits under out_stall
// reset (rst_n low, asynchronous) empties the pipeline and clears all
// configuration registers to zero
`default_nettype none

module ray_rectangle_intersect_unit import rri_pkg::*; #(
    parameter int COORD_FRAC_BITS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  coord_t             origin_x,
    input  coord_t             origin_y,
    input  coord_t             origin_z,
    input  coord_t             dir_x,
    input  coord_t             dir_y,
    input  coord_t             dir_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               is_hit,
    output reason_t            miss_reason,
    output logic               recorded,
    output logic               entering,
    output logic signed [31:0] distance,
    output coord_t             point_x,
    output coord_t             point_y,
    output coord_t             point_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  cfg_index_t         cfg_index,
    input  vec_packed_t        cfg_data
);

    vec_packed_t corner_reg, leg_u_reg, leg_v_reg, normal_reg;
    len_t        len_u_reg, len_v_reg;

    logic             advance;
    ray_t             ray;
    logic             f_valid;
    ray_info_t        f_info;
    logic [MAG_W-1:0] f_num_mag, f_den_mag;
    logic             d_valid;
    ray_info_t        d_info;
    logic [QUO_W-1:0] d_quo;
    logic             d_ovf;
    logic             b_valid;
    result_t          b_result;
    logic             out_valid_reg;
    result_t          result_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg <= '0;
            leg_u_reg  <= '0;
            leg_v_reg  <= '0;
            normal_reg <= '0;
            len_u_reg  <= '0;
            len_v_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CORNER: corner_reg <= cfg_data;
                CFG_LEG_U:  leg_u_reg  <= cfg_data;
                CFG_LEG_V:  leg_v_reg  <= cfg_data;
                CFG_NORMAL: normal_reg <= cfg_data;
                CFG_LEN_U:  len_u_reg  <= cfg_data[47:0];
                CFG_LEN_V:  len_v_reg  <= cfg_data[47:0];
                default:    ;
            endcase
        end
    end

    // every stage moves together unless a finished item is held
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    assign ray.ox = origin_x;
    assign ray.oy = origin_y;
    assign ray.oz = origin_z;
    assign ray.dx = dir_x;
    assign ray.dy = dir_y;
    assign ray.dz = dir_z;

    rri_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (in_valid),
        .ray       (ray),
        .corner    (corner_reg),
        .normal    (normal_reg),
        .out_valid (f_valid),
        .info      (f_info),
        .num_mag   (f_num_mag),
        .den_mag   (f_den_mag)
    );

    rri_divider #(
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (f_valid),
        .in_info   (f_info),
        .num_mag   (f_num_mag),
        .den_mag   (f_den_mag),
        .out_valid (d_valid),
        .out_info  (d_info),
        .quo       (d_quo),
        .ovf       (d_ovf)
    );

    rri_point #(
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_point (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (d_valid),
        .in_info   (d_info),
        .quo       (d_quo),
        .ovf       (d_ovf),
        .corner    (corner_reg),
        .leg_u     (leg_u_reg),
        .leg_v     (leg_v_reg),
        .len_u     (len_u_reg),
        .len_v     (len_v_reg),
        .out_valid (b_valid),
        .result    (b_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= b_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign is_hit      = result_reg.is_hit;
    assign miss_reason = result_reg.miss_reason;
    assign recorded    = result_reg.recorded;
    assign entering    = result_reg.entering;
    assign distance    = result_reg.distance;
    assign point_x     = result_reg.point_x;
    assign point_y     = result_reg.point_y;
    assign point_z     = result_reg.point_z;

endmodule

`default_nettype wire

// File: design/rri_front.sv
`default_nettype none

module rri_front import rri_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  ray_t               ray,
    input  vec_packed_t        corner,
    input  vec_packed_t        normal,
    output logic               out_valid,
    output ray_info_t          info,
    output logic [MAG_W-1:0]   num_mag,
    output logic [MAG_W-1:0]   den_mag
);

    coord_t o [3];
    coord_t d [3];
    logic signed [20:0] diff [3];
    logic signed [40:0] pn_next [3];
    logic signed [40:0] pn_reg  [3];
    logic signed [39:0] pd_next [3];
    logic signed [39:0] pd_reg  [3];
    ray_t               ray1_reg;
    logic               v1_reg;

    logic signed [NUM_W-1:0] num_next, num_reg;
    logic signed [NUM_W-1:0] den_next, den_reg;
    ray_t                    ray2_reg;
    logic                    v2_reg;

    logic signed [NUM_W-1:0] abs_num, abs_den;
    ray_info_t               info_next, info_reg;
    logic [MAG_W-1:0]        num_mag_reg, den_mag_reg;
    logic                    v3_reg;

    always_comb
    begin
        o[0] = ray.ox;
        o[1] = ray.oy;
        o[2] = ray.oz;
        d[0] = ray.dx;
        d[1] = ray.dy;
        d[2] = ray.dz;
        for (int i = 0; i < 3; i++)
        begin
            diff[i]    = 21'(comp(corner, i)) - 21'(o[i]);
            pn_next[i] = 41'(diff[i]) * 41'(comp(normal, i));
            pd_next[i] = 40'(d[i]) * 40'(comp(normal, i));
        end
    end

    always_comb
    begin
        num_next = NUM_W'(pn_reg[0]) + NUM_W'(pn_reg[1]) + NUM_W'(pn_reg[2]);
        den_next = NUM_W'(pd_reg[0]) + NUM_W'(pd_reg[1]) + NUM_W'(pd_reg[2]);
    end

    always_comb
    begin
        abs_num            = num_reg[NUM_W-1] ? -num_reg : num_reg;
        abs_den            = den_reg[NUM_W-1] ? -den_reg : den_reg;
        info_next.ray      = ray2_reg;
        info_next.parallel = (den_reg == '0);
        info_next.neg      = (num_reg != '0) && (num_reg[NUM_W-1] != den_reg[NUM_W-1]);
        info_next.den_neg  = den_reg[NUM_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ray1_reg    <= ray;
            pn_reg      <= pn_next;
            pd_reg      <= pd_next;
            ray2_reg    <= ray1_reg;
            num_reg     <= num_next;
            den_reg     <= den_next;
            info_reg    <= info_next;
            num_mag_reg <= abs_num[MAG_W-1:0];
            den_mag_reg <= abs_den[MAG_W-1:0];
        end
    end

    assign out_valid = v3_reg;
    assign info      = info_reg;
    assign num_mag   = num_mag_reg;
    assign den_mag   = den_mag_reg;

endmodule

`default_nettype wire

// File: design/rri_divider.sv
`default_nettype none

module rri_divider import rri_pkg::*; #(
    parameter int FRAC_BITS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  ray_info_t          in_info,
    input  logic [MAG_W-1:0]   num_mag,
    input  logic [MAG_W-1:0]   den_mag,
    output logic               out_valid,
    output ray_info_t          out_info,
    output logic [QUO_W-1:0]   quo,
    output logic               ovf
);

    localparam int REM_W  = MAG_W + QUO_W;
    localparam int STAGES = QUO_W;

    logic [REM_W-1:0] rem_reg  [STAGES+1];
    logic [QUO_W-1:0] quo_reg  [STAGES+1];
    logic [MAG_W-1:0] den_reg  [STAGES+1];
    ray_info_t        info_reg [STAGES+1];
    logic             ovf_reg  [STAGES+1];
    logic [STAGES:0]  valid_reg;

    logic [REM_W-1:0] rem0_next;
    logic             ovf0_next;

    // quotient above 33 bits is flagged here and saturated later
    always_comb
    begin
        rem0_next = REM_W'(num_mag) << FRAC_BITS;
        ovf0_next = rem0_next >= (REM_W'(den_mag) << QUO_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem0_next;
            quo_reg[0]  <= '0;
            den_reg[0]  <= den_mag;
            info_reg[0] <= in_info;
            ovf_reg[0]  <= ovf0_next;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar k = 1; k <= STAGES; k++)
    begin : g_stage
        localparam int BIT = STAGES - k;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        always_comb
        begin
            trial    = REM_W'(den_reg[k-1]) << BIT;
            rem_next = rem_reg[k-1];
            quo_next = quo_reg[k-1];
            if (rem_reg[k-1] >= trial)
            begin
                rem_next      = rem_reg[k-1] - trial;
                quo_next[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                den_reg[k]  <= den_reg[k-1];
                info_reg[k] <= info_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[STAGES];
    assign out_info  = info_reg[STAGES];
    assign quo       = quo_reg[STAGES];
    assign ovf       = ovf_reg[STAGES];

endmodule

`default_nettype wire

// File: design/rri_point.sv
`default_nettype none

module rri_point import rri_pkg::*; #(
    parameter int FRAC_BITS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  ray_info_t          in_info,
    input  logic [QUO_W-1:0]   quo,
    input  logic               ovf,
    input  vec_packed_t        corner,
    input  vec_packed_t        leg_u,
    input  vec_packed_t        leg_v,
    input  len_t               len_u,
    input  len_t               len_v,
    output logic               out_valid,
    output result_t            result
);

    localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
    localparam logic signed [52:0] P_MAX = 53'sd1099511627775;
    localparam logic signed [52:0] P_MIN = -53'sd1099511627776;
    localparam logic signed [40:0] C_MAX = 41'sd524287;
    localparam logic signed [40:0] C_MIN = -41'sd524288;

    function automatic coord_t sat20(input logic signed [40:0] v);
        coord_t r;
        if (v > C_MAX)
        begin
            r = coord_t'(C_MAX[19:0]);
        end
        else if (v < C_MIN)
        begin
            r = coord_t'(C_MIN[19:0]);
        end
        else
        begin
            r = v[19:0];
        end
        return r;
    endfunction

    logic [5:0] v_reg;

    // b1: saturate t
    logic [QUO_W-1:0]   neg_q;
    logic signed [31:0] t1_next, t1_reg;
    ray_info_t          info1_reg;

    // b2: t * d
    coord_t             d [3];
    logic signed [51:0] prod_next [3];
    logic signed [51:0] prod_reg  [3];
    logic signed [31:0] t2_reg;
    ray_info_t          info2_reg;

    // b3: point
    coord_t             o [3];
    logic signed [51:0] prod_sh [3];
    logic signed [52:0] psum [3];
    logic signed [40:0] p3_next [3];
    logic signed [40:0] p3_reg  [3];
    logic signed [31:0] t3_reg;
    ray_info_t          info3_reg;

    // b4: offset from corner
    logic signed [41:0] e4_next [3];
    logic signed [41:0] e4_reg  [3];
    logic signed [40:0] p4_reg  [3];
    logic signed [31:0] t4_reg;
    ray_info_t          info4_reg;

    // b5: projection products
    logic signed [61:0] mu_next [3];
    logic signed [61:0] mv_next [3];
    logic signed [61:0] mu_reg  [3];
    logic signed [61:0] mv_reg  [3];
    logic signed [40:0] p5_reg  [3];
    logic signed [31:0] t5_reg;
    ray_info_t          info5_reg;

    // b6: range tests
    logic signed [63:0] du, dv, lu, lv;
    logic               out_u_next, out_v_next, out_u_reg, out_v_reg;
    logic signed [40:0] p6_reg  [3];
    logic signed [31:0] t6_reg;
    ray_info_t          info6_reg;

    always_comb
    begin
        neg_q = -quo;
        if (ovf)
        begin
            t1_next = in_info.neg ? T_MIN : T_MAX;
        end
        else if (in_info.neg)
        begin
            t1_next = (quo > QUO_W'(33'h0_8000_0000)) ? T_MIN : neg_q[31:0];
        end
        else
        begin
            t1_next = (quo > QUO_W'(33'h0_7FFF_FFFF)) ? T_MAX : quo[31:0];
        end
    end

    always_comb
    begin
        d[0] = info1_reg.ray.dx;
        d[1] = info1_reg.ray.dy;
        d[2] = info1_reg.ray.dz;
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = 52'(t1_reg) * 52'(d[i]);
        end
    end

    always_comb
    begin
        o[0] = info2_reg.ray.ox;
        o[1] = info2_reg.ray.oy;
        o[2] = info2_reg.ray.oz;
        for (int i = 0; i < 3; i++)
        begin
            prod_sh[i] = prod_reg[i] >>> FRAC_BITS;
            psum[i]    = 53'(prod_sh[i]) + 53'(o[i]);
            if (psum[i] > P_MAX)
            begin
                p3_next[i] = P_MAX[40:0];
            end
            else if (psum[i] < P_MIN)
            begin
                p3_next[i] = P_MIN[40:0];
            end
            else
            begin
                p3_next[i] = psum[i][40:0];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e4_next[i] = 42'(p3_reg[i]) - 42'(comp(corner, i));
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mu_next[i] = 62'(e4_reg[i]) * 62'(comp(leg_u, i));
            mv_next[i] = 62'(e4_reg[i]) * 62'(comp(leg_v, i));
        end
    end

    always_comb
    begin
        du         = 64'(mu_reg[0]) + 64'(mu_reg[1]) + 64'(mu_reg[2]);
        dv         = 64'(mv_reg[0]) + 64'(mv_reg[1]) + 64'(mv_reg[2]);
        lu         = {16'b0, len_u};
        lv         = {16'b0, len_v};
        out_u_next = (du < 0) || (du > lu);
        out_v_next = (dv < 0) || (dv > lv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg    <= t1_next;
            info1_reg <= in_info;
            prod_reg  <= prod_next;
            t2_reg    <= t1_reg;
            info2_reg <= info1_reg;
            p3_reg    <= p3_next;
            t3_reg    <= t2_reg;
            info3_reg <= info2_reg;
            e4_reg    <= e4_next;
            p4_reg    <= p3_reg;
            t4_reg    <= t3_reg;
            info4_reg <= info3_reg;
            mu_reg    <= mu_next;
            mv_reg    <= mv_next;
            p5_reg    <= p4_reg;
            t5_reg    <= t4_reg;
            info5_reg <= info4_reg;
            out_u_reg <= out_u_next;
            out_v_reg <= out_v_next;
            p6_reg    <= p5_reg;
            t6_reg    <= t5_reg;
            info6_reg <= info5_reg;
        end
    end

    always_comb
    begin
        result.recorded = 1'b0;
        result.entering = 1'b0;
        result.distance = t6_reg;
        result.point_x  = sat20(p6_reg[0]);
        result.point_y  = sat20(p6_reg[1]);
        result.point_z  = sat20(p6_reg[2]);
        if (info6_reg.parallel)
        begin
            result.miss_reason = REASON_PARALLEL;
            result.distance    = '0;
            result.point_x     = '0;
            result.point_y     = '0;
            result.point_z     = '0;
        end
        else if (out_u_reg)
        begin
            result.miss_reason = REASON_OUTSIDE_U;
        end
        else if (out_v_reg)
        begin
            result.miss_reason = REASON_OUTSIDE_V;
        end
        else
        begin
            result.recorded    = 1'b1;
            result.entering    = info6_reg.den_neg;
            result.miss_reason = info6_reg.neg ? REASON_BEHIND : REASON_HIT;
        end
        result.is_hit = (result.miss_reason == REASON_HIT);
    end

    assign out_valid = v_reg[5];

endmodule

`default_nettype wire

// File: design/rri_checker.sv
`default_nettype none

module rri_checker import rri_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic               is_hit,
    input reason_t            miss_reason,
    input logic               recorded,
    input logic               entering,
    input logic signed [31:0] distance
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_hit == (miss_reason == REASON_HIT)))
        else $error("is_hit disagrees with miss_reason");

    a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (miss_reason == REASON_PARALLEL)
            |-> (distance == 0) && !recorded && !entering)
        else $error("parallel item carries data");

    a_outside_unrec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((miss_reason == REASON_OUTSIDE_U) || (miss_reason == REASON_OUTSIDE_V))
            |-> !recorded && !entering)
        else $error("outside item marked recorded");

    a_recorded_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && recorded
            |-> (miss_reason == REASON_HIT) || (miss_reason == REASON_BEHIND))
        else $error("recorded item with wrong reason");

endmodule

bind ray_rectangle_intersect_unit rri_checker u_rri_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .is_hit      (is_hit),
    .miss_reason (miss_reason),
    .recorded    (recorded),
    .entering    (entering),
    .distance    (distance)
);

`default_nettype wire
